// ===== rtl/load_cell_adc_serial_reader_defines.svh =====
// assertion macros for the load cell converter serial reader
`ifndef LOAD_CELL_ADC_SERIAL_READER_DEFINES_SVH
`define LOAD_CELL_ADC_SERIAL_READER_DEFINES_SVH

`ifndef SYNTH
// checked only while out of reset
`define LCASR_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");
// checked at every edge, reset included
`define LCASR_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed");
`else
`define LCASR_ASSERT(label, prop)
`define LCASR_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== rtl/lcasr_pkg.sv =====
// constants and types for the load cell converter serial reader
package lcasr_pkg;

  localparam int DataBits      = 24;
  localparam int ScaleFracBits = 4;
  localparam int ScaleBits     = 16;
  localparam int RawBits       = 24;
  localparam int WeightBits    = 28;
  localparam int OpBits        = 2;
  localparam int NumBits       = DataBits + ScaleFracBits;
  localparam int CntBits       = $clog2(DataBits + 1);
  localparam int DivCntBits    = $clog2(NumBits + 1);

  localparam logic [ScaleBits-1:0] ScaleReset = ScaleBits'(6880);
  localparam logic [DataBits-1:0]  TopBit     = DataBits'(1) << (DataBits - 1);

  localparam logic [OpBits-1:0] OpTick    = 2'd0;
  localparam logic [OpBits-1:0] OpTare    = 2'd1;
  localparam logic [OpBits-1:0] OpMeasure = 2'd2;

  typedef enum logic [5:0] {
    PhIdle  = 6'b000001,
    PhWait  = 6'b000010,
    PhHigh  = 6'b000100,
    PhLow   = 6'b001000,
    PhLastH = 6'b010000,
    PhLastL = 6'b100000
  } phase_e;

  typedef enum logic [1:0] {
    CtlRun = 2'b01,
    CtlDiv = 2'b10
  } ctl_e;

endpackage

// ===== rtl/load_cell_adc_serial_reader.sv =====
// Serial reader for a 24-bit load cell converter: one tick in drives the clock pin for that
// tick and gives one result out. A tick is taken each clock while the divider is idle and the
// result register is free. The completion tick of a measurement whose word lies above the
// tare holds the input while the compare-and-subtract divider forms 28 quotient bits, one a
// cycle, and then, once the result register is free, loads its result (new weight) there;
// every other tick loads its result straight into the result register.
`include "load_cell_adc_serial_reader_defines.svh"

module load_cell_adc_serial_reader (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [lcasr_pkg::OpBits-1:0]     opcode_i,
  input  logic                             data_line_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             clock_line_o,
  output logic                             busy_res_o,
  output logic                             done_res_o,
  output logic [lcasr_pkg::RawBits-1:0]    raw_word_o,
  output logic [lcasr_pkg::WeightBits-1:0] weight_o,
  output logic                             weight_updated_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lcasr_pkg::ScaleBits-1:0]  cfg_data_i
);
  import lcasr_pkg::*;

  // control state
  ctl_e                  ctl_q, ctl_d;
  phase_e                phase_q, phase_d;
  logic                  pend_meas_q, pend_meas_d;
  logic [CntBits-1:0]    bit_cnt_q, bit_cnt_d;
  logic [DivCntBits-1:0] div_cnt_q, div_cnt_d;
  logic                  out_valid_q, out_valid_d;

  // data state
  logic [ScaleBits-1:0]  scale_q;
  logic [DataBits-1:0]   shift_q, shift_d;
  logic [DataBits-1:0]   last_raw_q, last_raw_d;
  logic [DataBits-1:0]   tare_q, tare_d;
  logic [WeightBits-1:0] weight_q, weight_d;
  logic [ScaleBits:0]    rem_q, rem_d;
  logic [NumBits-1:0]    quo_q, quo_d;

  logic                  out_clk_q, out_busy_q, out_done_q, out_upd_q;
  logic [RawBits-1:0]    out_raw_q;
  logic [WeightBits-1:0] out_weight_q;

  logic                  out_free, in_accept, div_start, div_finish;
  logic                  tk_clk, tk_busy, tk_done;
  logic [CntBits-1:0]    cnt_inc;
  logic [DataBits-1:0]   word, net_counts;
  logic [ScaleBits:0]    rem_sh, rem_diff;
  logic                  rem_ge;
  logic [WeightBits-1:0] weight_sat;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (ctl_q != CtlRun) || !out_free;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (ctl_q == CtlRun);

  assign cnt_inc    = bit_cnt_q + 1'b1;
  assign word       = shift_q ^ TopBit;
  assign net_counts = word - tare_q;

  // tick phase sequencing
  always_comb begin
    phase_d     = phase_q;
    pend_meas_d = pend_meas_q;
    bit_cnt_d   = bit_cnt_q;
    shift_d     = shift_q;
    last_raw_d  = last_raw_q;
    tare_d      = tare_q;
    tk_clk      = 1'b0;
    tk_busy     = 1'b1;
    tk_done     = 1'b0;
    div_start   = 1'b0;
    case (phase_q)
      PhWait: begin
        if (!data_line_i) begin
          phase_d   = PhHigh;
          bit_cnt_d = '0;
          shift_d   = '0;
        end
      end
      PhHigh: begin
        tk_clk  = 1'b1;
        phase_d = PhLow;
      end
      PhLow: begin
        shift_d   = {shift_q[DataBits-2:0], data_line_i};
        bit_cnt_d = cnt_inc;
        phase_d   = (cnt_inc >= CntBits'(DataBits)) ? PhLastH : PhHigh;
      end
      PhLastH: begin
        tk_clk  = 1'b1;
        phase_d = PhLastL;
      end
      PhLastL: begin
        tk_busy    = 1'b0;
        tk_done    = 1'b1;
        last_raw_d = word;
        phase_d    = PhIdle;
        if (!pend_meas_q) begin
          tare_d = word;
        end else if (word > tare_q) begin
          div_start = 1'b1;
        end
      end
      default: begin
        phase_d = PhIdle;
        if (opcode_i == OpTare || opcode_i == OpMeasure) begin
          pend_meas_d = (opcode_i == OpMeasure);
          phase_d     = PhWait;
        end else begin
          tk_busy = 1'b0;
        end
      end
    endcase
  end

  // one restoring divide step per cycle
  assign rem_sh   = {rem_q[ScaleBits-1:0], quo_q[NumBits-1]};
  assign rem_ge   = rem_sh >= {1'b0, scale_q};
  assign rem_diff = rem_sh - {1'b0, scale_q};

  assign weight_sat = ((scale_q == '0) || ((quo_q >> WeightBits) != '0)) ? '1
                    : WeightBits'(quo_q);

  assign div_finish = (ctl_q == CtlDiv) && (div_cnt_q == '0) && out_free;

  always_comb begin
    ctl_d     = ctl_q;
    div_cnt_d = div_cnt_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    weight_d  = weight_q;
    case (ctl_q)
      CtlDiv: begin
        if (div_cnt_q != '0) begin
          rem_d     = rem_ge ? rem_diff : rem_sh;
          quo_d     = {quo_q[NumBits-2:0], rem_ge};
          div_cnt_d = div_cnt_q - 1'b1;
        end else if (out_free) begin
          weight_d = weight_sat;
          ctl_d    = CtlRun;
        end
      end
      default: begin
        ctl_d = CtlRun;
        if (in_accept && div_start) begin
          rem_d     = '0;
          quo_d     = NumBits'(net_counts) << ScaleFracBits;
          div_cnt_d = DivCntBits'(NumBits);
          ctl_d     = CtlDiv;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if ((in_accept && !div_start) || div_finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= CtlRun;
      phase_q     <= PhIdle;
      pend_meas_q <= 1'b0;
      bit_cnt_q   <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      scale_q     <= ScaleReset;
      shift_q     <= '0;
      last_raw_q  <= '0;
      tare_q      <= '0;
      weight_q    <= '0;
    end else begin
      ctl_q       <= ctl_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
      weight_q    <= weight_d;
      if (cfg_valid_i && cfg_ready_o) begin
        scale_q <= cfg_data_i;
      end
      if (in_accept) begin
        phase_q     <= phase_d;
        pend_meas_q <= pend_meas_d;
        bit_cnt_q   <= bit_cnt_d;
        shift_q     <= shift_d;
        last_raw_q  <= last_raw_d;
        tare_q      <= tare_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (in_accept && !div_start) begin
      out_clk_q    <= tk_clk;
      out_busy_q   <= tk_busy;
      out_done_q   <= tk_done;
      out_upd_q    <= 1'b0;
      out_raw_q    <= RawBits'(last_raw_d);
      out_weight_q <= weight_q;
    end else if (div_finish) begin
      // completion of a measurement that moved the weight
      out_clk_q    <= 1'b0;
      out_busy_q   <= 1'b0;
      out_done_q   <= 1'b1;
      out_upd_q    <= 1'b1;
      out_raw_q    <= RawBits'(last_raw_q);
      out_weight_q <= weight_sat;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign clock_line_o     = out_clk_q;
  assign busy_res_o       = out_busy_q;
  assign done_res_o       = out_done_q;
  assign raw_word_o       = out_raw_q;
  assign weight_o         = out_weight_q;
  assign weight_updated_o = out_upd_q;

  `LCASR_ASSERT(a_div_start_loads_counter, (in_accept && div_start) |=>
                (ctl_q == CtlDiv && div_cnt_q == DivCntBits'(NumBits)))
  `LCASR_ASSERT(a_div_finish_gives_update, div_finish |=> (out_valid_q && out_upd_q && out_done_q))
  `LCASR_ASSERT(a_update_only_on_done, (out_valid_o && weight_updated_o) |-> (done_res_o && !busy_res_o))
  `LCASR_ASSERT(a_clock_high_only_busy, (out_valid_o && clock_line_o) |-> busy_res_o)
  `LCASR_ASSERT_ALWAYS(a_quiet_in_reset, !rst_ni |=> (!out_valid_o && ctl_q == CtlRun))

endmodule

// ===== dv/load_cell_adc_serial_reader_test.sv =====
// tick-level testbench for the load cell converter serial reader: table and random tick streams
module load_cell_adc_serial_reader_test;
  import lcasr_pkg::*;

  localparam logic [OpBits-1:0] OpIgnored = 2'd3;
  localparam int SettleCycles = 40;
  localparam int PhaseTicks = 200;

  typedef struct packed {
    logic                  clock_line;
    logic                  busy;
    logic                  done;
    logic [RawBits-1:0]    raw;
    logic [WeightBits-1:0] weight;
    logic                  updated;
  } reading_t;

  typedef struct {
    logic [OpBits-1:0]  op;
    logic               data;
    int unsigned        waits;
    logic [RawBits-1:0] word;
    logic [OpBits-1:0]  busy_op;
    bit                 typed;
    reading_t           final_r;
  } plan_row_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [OpBits-1:0]     opcode_i = OpTick;
  logic                  data_line_i = 1'b1;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  clock_line_o;
  logic                  busy_res_o;
  logic                  done_res_o;
  logic [RawBits-1:0]    raw_word_o;
  logic [WeightBits-1:0] weight_o;
  logic                  weight_updated_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [ScaleBits-1:0]  cfg_data_i = '0;

  // predicted reader state
  phase_e                rd_phase;
  logic                  measure_pending;
  logic [CntBits-1:0]    bits_taken;
  logic [DataBits-1:0]   shift_q;
  logic [RawBits-1:0]    raw_q;
  logic [RawBits-1:0]    tare_q;
  logic [WeightBits-1:0] weight_q;
  logic [ScaleBits-1:0]  scale_q;

  reading_t    pending_readings[$];
  plan_row_t   directed_plan[$];
  reading_t    want_r;
  int unsigned ticks_sent = 0;
  int unsigned mismatches = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;

  load_cell_adc_serial_reader DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .data_line_i      (data_line_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .clock_line_o     (clock_line_o),
    .busy_res_o       (busy_res_o),
    .done_res_o       (done_res_o),
    .raw_word_o       (raw_word_o),
    .weight_o         (weight_o),
    .weight_updated_o (weight_updated_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  function automatic reading_t make_reading(logic done, logic [RawBits-1:0] raw,
                                            logic [WeightBits-1:0] weight, logic updated);
    reading_t r;
    r = '0;
    r.done = done;
    r.raw = raw;
    r.weight = weight;
    r.updated = updated;
    return r;
  endfunction

  // one half-bit tick of the reader
  function automatic reading_t advance_reader(logic [OpBits-1:0] op, logic data);
    reading_t r;
    logic [RawBits-1:0] word;
    logic [NumBits-1:0] num;
    r = '0;
    r.busy = 1'b1;
    case (rd_phase)
      PhWait: begin
        if (!data) begin
          rd_phase = PhHigh;
          bits_taken = '0;
          shift_q = '0;
        end
      end
      PhHigh: begin
        r.clock_line = 1'b1;
        rd_phase = PhLow;
      end
      PhLow: begin
        shift_q = {shift_q[DataBits-2:0], data};
        bits_taken = bits_taken + 1'b1;
        rd_phase = (bits_taken >= DataBits) ? PhLastH : PhHigh;
      end
      PhLastH: begin
        r.clock_line = 1'b1;
        rd_phase = PhLastL;
      end
      PhLastL: begin
        word = shift_q ^ TopBit;
        r.busy = 1'b0;
        r.done = 1'b1;
        raw_q = word;
        if (!measure_pending) begin
          tare_q = word;
        end else if (word > tare_q) begin
          num = NumBits'(word - tare_q) << ScaleFracBits;
          weight_q = (scale_q == '0) ? '1 : WeightBits'(num / scale_q);
          r.updated = 1'b1;
        end
        rd_phase = PhIdle;
      end
      default: begin
        rd_phase = PhIdle;
        if (op == OpTare || op == OpMeasure) begin
          measure_pending = (op == OpMeasure);
          rd_phase = PhWait;
        end else begin
          r.busy = 1'b0;
        end
      end
    endcase
    r.raw = raw_q;
    r.weight = weight_q;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s at %0t: got %0h, expected %0h", field, $time, got, want);
    mismatches++;
  endtask

  task automatic send_tick(logic [OpBits-1:0] op, logic data, bit typed, reading_t typed_r);
    reading_t r;
    in_valid_i <= 1'b1;
    opcode_i <= op;
    data_line_i <= data;
    do @(posedge clk_i); while (in_stall_o);
    r = advance_reader(op, data);
    pending_readings.push_back(typed ? typed_r : r);
    ticks_sent++;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // full conversion: start, wait for data low, 24 pulses, final pulse, completion
  task automatic run_conversion(logic [OpBits-1:0] kind, int unsigned waits,
                                logic [RawBits-1:0] word, logic [OpBits-1:0] busy_op,
                                bit typed, reading_t done_r);
    logic [DataBits-1:0] bits_out;
    bits_out = word ^ TopBit;
    send_tick(kind, 1'($urandom_range(1)), 1'b0, '0);
    repeat (waits) send_tick(busy_op, 1'b1, 1'b0, '0);
    send_tick(busy_op, 1'b0, 1'b0, '0);
    for (int i = DataBits - 1; i >= 0; i--) begin
      // line is not sampled on the high half
      send_tick(busy_op, 1'($urandom_range(1)), 1'b0, '0);
      send_tick(busy_op, bits_out[i], 1'b0, '0);
    end
    send_tick(busy_op, 1'($urandom_range(1)), 1'b0, '0);
    send_tick(busy_op, 1'($urandom_range(1)), typed, done_r);
  endtask

  task automatic add_row(logic [OpBits-1:0] op, logic data, int unsigned waits,
                         logic [RawBits-1:0] word, logic [OpBits-1:0] busy_op,
                         bit typed, reading_t final_r);
    plan_row_t row;
    row.op = op;
    row.data = data;
    row.waits = waits;
    row.word = word;
    row.busy_op = busy_op;
    row.typed = typed;
    row.final_r = final_r;
    directed_plan.push_back(row);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected transaction", 32'(raw_word_o), 32'd0);
      end else begin
        want_r = pending_readings.pop_front();
        if (clock_line_o !== want_r.clock_line)
          report_mismatch("clock_line", 32'(clock_line_o), 32'(want_r.clock_line));
        if (busy_res_o !== want_r.busy)
          report_mismatch("busy", 32'(busy_res_o), 32'(want_r.busy));
        if (done_res_o !== want_r.done)
          report_mismatch("done", 32'(done_res_o), 32'(want_r.done));
        if (raw_word_o !== want_r.raw)
          report_mismatch("raw_word", 32'(raw_word_o), 32'(want_r.raw));
        if (weight_o !== want_r.weight)
          report_mismatch("weight", 32'(weight_o), 32'(want_r.weight));
        if (weight_updated_o !== want_r.updated)
          report_mismatch("weight_updated", 32'(weight_updated_o), 32'(want_r.updated));
      end
    end
  end

  initial begin
    logic [ScaleBits-1:0] next_scale;
    logic [RawBits-1:0]   w;
    int unsigned          stop_at;
    rd_phase = PhIdle;
    measure_pending = 1'b0;
    bits_taken = '0;
    shift_q = '0;
    raw_q = '0;
    tare_q = '0;
    weight_q = '0;
    scale_q = ScaleReset;

    // ticks after reset, then conversions at the word extremes around the tare and three with random words
    add_row(OpTick, 1'b1, 0, '0, OpTick, 1'b1, make_reading(1'b0, '0, '0, 1'b0));
    add_row(OpIgnored, 1'b0, 0, '0, OpTick, 1'b1, make_reading(1'b0, '0, '0, 1'b0));
    add_row(OpTare, 1'b0, 2, 24'h800000, OpMeasure, 1'b1,
            make_reading(1'b1, 24'h800000, '0, 1'b0));
    add_row(OpMeasure, 1'b0, 1, 24'hFFFFFF, OpTare, 1'b1,
            make_reading(1'b1, 24'hFFFFFF, 28'd19508, 1'b1));
    add_row(OpMeasure, 1'b0, 0, 24'h800000, OpIgnored, 1'b1,
            make_reading(1'b1, 24'h800000, 28'd19508, 1'b0));
    add_row(OpMeasure, 1'b0, 3, 24'h000000, OpTick, 1'b1,
            make_reading(1'b1, 24'h000000, 28'd19508, 1'b0));
    add_row(OpMeasure, 1'b0, 0, 24'h800001, OpMeasure, 1'b1,
            make_reading(1'b1, 24'h800001, '0, 1'b1));
    add_row(OpTick, 1'b0, 0, '0, OpTick, 1'b1, make_reading(1'b0, 24'h800001, '0, 1'b0));
    add_row(OpTare, 1'b0, 0, 24'hFFFFFF, OpTick, 1'b1,
            make_reading(1'b1, 24'hFFFFFF, '0, 1'b0));
    add_row(OpMeasure, 1'b0, 0, 24'hFFFFFF, OpTare, 1'b1,
            make_reading(1'b1, 24'hFFFFFF, '0, 1'b0));
    add_row(OpTare, 1'b0, 1, 24'h000000, OpIgnored, 1'b1,
            make_reading(1'b1, 24'h000000, '0, 1'b0));
    add_row(OpMeasure, 1'b0, 0, 24'hFFFFFF, OpMeasure, 1'b1,
            make_reading(1'b1, 24'hFFFFFF, 28'd39016, 1'b1));
    add_row(OpMeasure, 1'b0, 2, RawBits'($urandom), OpTick, 1'b0, '0);
    add_row(OpTare, 1'b0, 0, RawBits'($urandom), OpMeasure, 1'b0, '0);
    add_row(OpMeasure, 1'b0, 1, RawBits'($urandom), OpIgnored, 1'b0, '0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].op == OpTare || directed_plan[i].op == OpMeasure)
        run_conversion(directed_plan[i].op, directed_plan[i].waits, directed_plan[i].word,
                       directed_plan[i].busy_op, directed_plan[i].typed,
                       directed_plan[i].final_r);
      else
        send_tick(directed_plan[i].op, directed_plan[i].data, directed_plan[i].typed,
                  directed_plan[i].final_r);
    end

    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        wait_idle();
        case (p)
          1:       next_scale = 16'd1;
          2:       next_scale = '1;
          3:       next_scale = ScaleBits'($urandom_range(65535, 1));
          default: next_scale = ScaleBits'($urandom_range(200, 1));
        endcase
        cfg_valid_i <= 1'b1;
        cfg_data_i <= next_scale;
        do @(posedge clk_i); while (!cfg_ready_o);
        cfg_valid_i <= 1'b0;
        scale_q = next_scale;
      end
      case (p % 4)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 80; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 80; end
        default: begin gap_pct = 23; stall_pct = 23; end
      endcase
      stop_at = ticks_sent + PhaseTicks;
      while (ticks_sent < stop_at) begin
        if ($urandom_range(99) < 75) begin
          // words placed around the current tare, at the extremes or at random
          case ($urandom_range(6))
            0:       w = tare_q;
            1:       w = tare_q + 1'b1;
            2:       w = tare_q - 1'b1;
            3:       w = '0;
            4:       w = '1;
            5:       w = tare_q + RawBits'($urandom_range(4095));
            default: w = RawBits'($urandom);
          endcase
          run_conversion(($urandom_range(4) == 0) ? OpTare : OpMeasure, $urandom_range(3), w,
                         OpBits'($urandom_range(3)), 1'b0, '0);
        end else begin
          // random ticks, then run out whatever conversion they started
          repeat ($urandom_range(6, 1))
            send_tick(OpBits'($urandom_range(3)), 1'($urandom_range(1)), 1'b0, '0);
          while (rd_phase != PhIdle)
            send_tick(OpBits'($urandom_range(3)), 1'($urandom_range(1)), 1'b0, '0);
        end
      end
    end

    wait_idle();
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lcasr_pkg.sv
rtl/load_cell_adc_serial_reader.sv
dv/load_cell_adc_serial_reader_test.sv
